[sv/bcdd_pkg.sv]
// Shared types, codes and sequencing functions for the blink-code digit display.
// No dependencies; compiled first.
package bcdd_pkg;

  localparam int TIMER_BITS = 16;

  localparam logic [15:0] FLASH_TICKS_RST  = 16'd250;
  localparam logic [15:0] GAP_TICKS_RST    = 16'd500;
  localparam logic [3:0]  REPEAT_COUNT_RST = 4'd3;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_FLASH_TICKS  = 2'd0;
  localparam logic [1:0] REG_GAP_TICKS    = 2'd1;
  localparam logic [1:0] REG_REPEAT_COUNT = 2'd2;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  // Sequencer phases; numeric order is the order within one pass
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_BLUE  = 3'd1;
  localparam logic [2:0] PH_RED   = 3'd2;
  localparam logic [2:0] PH_GAP1  = 3'd3;
  localparam logic [2:0] PH_GREEN = 3'd4;
  localparam logic [2:0] PH_GAP2  = 3'd5;

  typedef struct packed {
    logic [15:0] flash_ticks;
    logic [15:0] gap_ticks;
    logic [3:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic [3:0]            pass_left;
    logic [3:0]            flashes_left;
    logic                  light_on;
    logic [TIMER_BITS-1:0] timer;
  } seq_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic busy_res;
  } led_t;

  function automatic logic [TIMER_BITS-1:0] timer_load(logic [15:0] t);
    logic [31:0] ext;
    logic [31:0] mx;
    ext = 32'(t);
    mx  = 32'((64'd1 << TIMER_BITS) - 64'd1);
    return (ext > mx) ? mx[TIMER_BITS-1:0] : ext[TIMER_BITS-1:0];
  endfunction

  function automatic logic [TIMER_BITS-1:0] flash_load(logic [15:0] t);
    return timer_load((t == 16'd0) ? 16'd1 : t);
  endfunction

  // First phase at or after q that has something to show, else idle
  function automatic logic [2:0] first_from(logic [2:0] q, logic neg, logic [3:0] tens,
                                            logic [3:0] ones, logic gap_nz);
    logic [2:0] r;
    r = PH_IDLE;
    if (q <= PH_BLUE && neg) r = PH_BLUE;
    else if (q <= PH_RED && tens != 4'd0) r = PH_RED;
    else if (q <= PH_GAP1 && gap_nz) r = PH_GAP1;
    else if (q <= PH_GREEN && ones != 4'd0) r = PH_GREEN;
    else if (q <= PH_GAP2 && gap_nz) r = PH_GAP2;
    return r;
  endfunction

  // Enter phase p with pass count pass, skipping empty phases
  function automatic seq_t enter_phase(logic [2:0] p, logic [3:0] pass, logic neg,
                                       logic [3:0] tens, logic [3:0] ones, cfg_t cfg);
    seq_t       s;
    logic [2:0] t;
    logic [3:0] pl;
    logic       gap_nz;
    s      = '0;
    gap_nz = (cfg.gap_ticks != 16'd0);
    t      = PH_IDLE;
    pl     = pass;
    if (p != PH_IDLE) begin
      t = first_from(p, neg, tens, ones, gap_nz);
      if (t == PH_IDLE) begin
        // end of pass reached with nothing left: count the pass, restart
        pl = pass - 4'd1;
        if (pl != 4'd0) t = first_from(PH_BLUE, neg, tens, ones, gap_nz);
      end
    end
    case (t) inside
      PH_BLUE: begin
        s.flashes_left = 4'd1;
        s.light_on     = 1'b1;
        s.timer        = flash_load(cfg.flash_ticks);
      end
      PH_RED: begin
        s.flashes_left = tens;
        s.light_on     = 1'b1;
        s.timer        = flash_load(cfg.flash_ticks);
      end
      PH_GREEN: begin
        s.flashes_left = ones;
        s.light_on     = 1'b1;
        s.timer        = flash_load(cfg.flash_ticks);
      end
      PH_GAP1, PH_GAP2: begin
        s.timer = timer_load(cfg.gap_ticks);
      end
      default: begin
        s = '0;
      end
    endcase
    if (t != PH_IDLE) begin
      s.phase     = t;
      s.pass_left = pl;
    end
    return s;
  endfunction

endpackage

[sv/bcdd_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
interface bcdd_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [7:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
  modport mon    (input valid, input cmd, input value, input ready);
endinterface

interface bcdd_out_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;
  logic blue_on;
  logic busy_res;
  modport source (output valid, output red_on, output green_on, output blue_on,
                  output busy_res, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on,
                  input busy_res, output ready);
  modport mon    (input valid, input red_on, input green_on, input blue_on,
                  input busy_res, input ready);
endinterface

[sv/bcdd_core.sv]
// Blink sequencer state and its update for one item, taken when step_en is high.
// Depends on bcdd_pkg.
module bcdd_core
  import bcdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              cmd,
  input  logic signed [7:0] value,
  input  cfg_t              cfg,
  output led_t              leds
);

  seq_t       seq_r, seq_nxt;
  logic [3:0] tens_r, tens_nxt;
  logic [3:0] ones_r, ones_nxt;
  logic       neg_r, neg_nxt;

  logic signed [7:0]     v_sat;
  logic [7:0]            mag8;
  logic [6:0]            mag;
  logic [14:0]           prod;
  logic [3:0]            tens_new;
  logic [6:0]            tens_x10;
  logic [3:0]            ones_new;
  logic                  neg_new;
  logic [TIMER_BITS-1:0] t_dec;
  logic [3:0]            pl_dec;
  logic [3:0]            fl_dec;
  logic [2:0]            ph_after;

  // saturate and split into digits; tens = mag/10 via *205 >> 11 (exact to 99)
  always_comb begin
    if (value > 8'sd99) v_sat = 8'sd99;
    else if (value < -8'sd99) v_sat = -8'sd99;
    else v_sat = value;
    neg_new  = v_sat[7];
    mag8     = neg_new ? 8'(-v_sat) : 8'(v_sat);
    mag      = mag8[6:0];
    prod     = 15'(mag) * 15'd205;
    tens_new = prod[14:11];
    tens_x10 = 7'({tens_new, 3'b000}) + 7'({tens_new, 1'b0});
    ones_new = 4'(mag - tens_x10);
  end

  always_comb begin
    seq_nxt  = seq_r;
    tens_nxt = tens_r;
    ones_nxt = ones_r;
    neg_nxt  = neg_r;
    t_dec    = (seq_r.timer != '0) ? seq_r.timer - 1'b1 : seq_r.timer;
    pl_dec   = seq_r.pass_left - 4'd1;
    fl_dec   = seq_r.flashes_left - 4'd1;
    case (seq_r.phase)
      PH_BLUE: ph_after = PH_RED;
      PH_RED:  ph_after = PH_GAP1;
      default: ph_after = PH_GAP2;
    endcase
    if (cmd == CMD_SHOW) begin
      if (seq_r.phase == PH_IDLE) begin
        tens_nxt = tens_new;
        ones_nxt = ones_new;
        neg_nxt  = neg_new;
        if (cfg.repeat_count != 4'd0)
          seq_nxt = enter_phase(PH_BLUE, cfg.repeat_count, neg_new, tens_new, ones_new, cfg);
      end
    end else if (seq_r.phase != PH_IDLE) begin
      if (t_dec != '0) begin
        seq_nxt.timer = t_dec;
      end else if (seq_r.phase == PH_GAP1) begin
        seq_nxt = enter_phase(PH_GREEN, seq_r.pass_left, neg_r, tens_r, ones_r, cfg);
      end else if (seq_r.phase == PH_GAP2) begin
        seq_nxt = (pl_dec == 4'd0) ? '0
                : enter_phase(PH_BLUE, pl_dec, neg_r, tens_r, ones_r, cfg);
      end else if (seq_r.light_on) begin
        seq_nxt.light_on = 1'b0;
        seq_nxt.timer    = flash_load(cfg.flash_ticks);
      end else if (fl_dec != 4'd0) begin
        seq_nxt.flashes_left = fl_dec;
        seq_nxt.light_on     = 1'b1;
        seq_nxt.timer        = flash_load(cfg.flash_ticks);
      end else begin
        seq_nxt = enter_phase(ph_after, seq_r.pass_left, neg_r, tens_r, ones_r, cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      tens_r <= '0;
      ones_r <= '0;
      neg_r  <= 1'b0;
    end else if (step_en) begin
      seq_r  <= seq_nxt;
      tens_r <= tens_nxt;
      ones_r <= ones_nxt;
      neg_r  <= neg_nxt;
    end
  end

  assign leds.red_on   = (seq_r.phase == PH_RED)   && seq_r.light_on;
  assign leds.green_on = (seq_r.phase == PH_GREEN) && seq_r.light_on;
  assign leds.blue_on  = (seq_r.phase == PH_BLUE)  && seq_r.light_on;
  assign leds.busy_res = (seq_r.phase != PH_IDLE);

endmodule

[sv/blink_code_digit_display.sv]
// Blink-code digit display: an item goes through the input register, then the
// sequencer state update, to its result. Throughput is one item per cycle while
// the result is not stalled; one more item is taken while a result waits.
// The result fields decode the sequencer registers directly.
// Reset (rst_n low, synchronous) empties the pipeline, idles the sequencer and
// restores flash_ticks=250, gap_ticks=500, repeat_count=3.
module blink_code_digit_display
  import bcdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bcdd_in_if.sink     in_chan,
  bcdd_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_ticks  <= FLASH_TICKS_RST;
      cfg_r.gap_ticks    <= GAP_TICKS_RST;
      cfg_r.repeat_count <= REPEAT_COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FLASH_TICKS:  cfg_r.flash_ticks  <= pwdata[15:0];
        REG_GAP_TICKS:    cfg_r.gap_ticks    <= pwdata[15:0];
        REG_REPEAT_COUNT: cfg_r.repeat_count <= pwdata[3:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLASH_TICKS:  prdata = 32'(cfg_r.flash_ticks);
      REG_GAP_TICKS:    prdata = 32'(cfg_r.gap_ticks);
      REG_REPEAT_COUNT: prdata = 32'(cfg_r.repeat_count);
      default:          prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // s1 holds one accepted item; it is consumed when the result slot is free
  // or is being emptied in the same cycle.
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic signed [7:0] s1_value_r;
  logic              out_valid_r;
  logic              s1_adv;
  logic              step_en;

  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign step_en       = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r   <= in_chan.cmd;
      s1_value_r <= in_chan.value;
    end
  end

  // ---------------- sequencer / result register ----------------
  led_t leds;

  bcdd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cmd     (s1_cmd_r),
    .value   (s1_value_r),
    .cfg     (cfg_r),
    .leds    (leds)
  );

  // result slot: full after each step, empties on an output transfer with no new step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.red_on   = leds.red_on;
  assign out_chan.green_on = leds.green_on;
  assign out_chan.blue_on  = leds.blue_on;
  assign out_chan.busy_res = leds.busy_res;

endmodule

[sv/bcdd_checker.sv]
// Port-level checks for blink_code_digit_display, attached by bind.
// Depends on bcdd_if.
module bcdd_checker (
  input logic         clk,
  input logic         rst_n,
  bcdd_in_if.sink     in_chan,
  bcdd_out_if.source  out_chan
);

  // a stalled result keeps its valid and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable({out_chan.red_on, out_chan.green_on,
                                 out_chan.blue_on, out_chan.busy_res}))
    else $error("result changed or dropped while stalled");

  // at most one LED lit, and only while a sequence runs
  a_one_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      $onehot0({out_chan.red_on, out_chan.green_on, out_chan.blue_on}) &&
      (!(out_chan.red_on || out_chan.green_on || out_chan.blue_on) || out_chan.busy_res))
    else $error("LED lit outside a sequence or more than one LED lit");

  // a sink that takes results never throttles the input
  a_flow: assert property (@(posedge clk) out_chan.ready |-> in_chan.ready)
    else $error("input stalled while result side is ready");

  // reset empties the result slot
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

bind blink_code_digit_display bcdd_checker u_bcdd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
